[design/assert_macros.svh]
// Assertion helpers for the files that check behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a consequent follows an antecedent at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[design/fpqd_pkg.sv]
package fpqd_pkg;

  localparam int DATA_W            = 32;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Control that travels alongside each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic neg;    // operand signs differ
    logic dz;     // divisor was zero
  } ctrl_t;

endpackage

[design/fpqd_prep.sv]
module fpqd_prep #(
  parameter int FRAC_BITS = fpqd_pkg::FRAC_BITS_DEFAULT,
  localparam int DW = fpqd_pkg::DATA_W + FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [fpqd_pkg::DATA_W-1:0]     dividend,
  input  logic [fpqd_pkg::DATA_W-1:0]     divisor,
  output fpqd_pkg::ctrl_t                 ctrl,
  output logic [DW-1:0]                   num,
  output logic [fpqd_pkg::DATA_W-1:0]     den
);

  logic [fpqd_pkg::DATA_W-1:0] mag_a;
  logic [fpqd_pkg::DATA_W-1:0] mag_b;

  // Two's complement magnitude; the most negative value maps to 2^31 unsigned.
  always_comb begin
    mag_a = dividend[fpqd_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
    mag_b = divisor[fpqd_pkg::DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl.valid <= in_valid;
      ctrl.neg   <= dividend[fpqd_pkg::DATA_W-1] ^ divisor[fpqd_pkg::DATA_W-1];
      ctrl.dz    <= (divisor == '0);
    end
  end

  // Align the dividend magnitude by the fraction width.
  always_ff @(posedge clk) begin
    num <= DW'(mag_a) << FRAC_BITS;
    den <= mag_b;
  end

endmodule

[design/fpqd_div_stage.sv]
module fpqd_div_stage #(
  parameter int DW = fpqd_pkg::DATA_W + fpqd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fpqd_pkg::ctrl_t                 in_ctrl,
  input  logic [DW-1:0]                   in_num,
  input  logic [DW-1:0]                   in_quo,
  input  logic [fpqd_pkg::DATA_W-1:0]     in_rem,
  input  logic [fpqd_pkg::DATA_W-1:0]     in_den,
  output fpqd_pkg::ctrl_t                 out_ctrl,
  output logic [DW-1:0]                   out_num,
  output logic [DW-1:0]                   out_quo,
  output logic [fpqd_pkg::DATA_W-1:0]     out_rem,
  output logic [fpqd_pkg::DATA_W-1:0]     out_den
);

  localparam int RW = fpqd_pkg::DATA_W + 1;

  logic [RW-1:0] trial;
  logic [RW:0]   diff;
  logic          qbit;
  logic [fpqd_pkg::DATA_W-1:0] rem_next;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial    = {in_rem, in_num[DW-1]};
    diff     = {1'b0, trial} - {2'b00, in_den};
    qbit     = ~diff[RW];
    rem_next = qbit ? diff[fpqd_pkg::DATA_W-1:0] : trial[fpqd_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    out_num <= {in_num[DW-2:0], 1'b0};
    out_quo <= {in_quo[DW-2:0], qbit};
    out_rem <= rem_next;
    out_den <= in_den;
  end

endmodule

[design/fpqd_post.sv]
module fpqd_post #(
  parameter int DW = fpqd_pkg::DATA_W + fpqd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fpqd_pkg::ctrl_t                 in_ctrl,
  input  logic [DW-1:0]                   in_quo,
  output logic                            done,
  output logic [fpqd_pkg::DATA_W-1:0]     quotient,
  output logic                            overflow,
  output logic                            divide_by_zero
);

  localparam logic [DW-1:0] LIM_POS = DW'(33'h07FFF_FFFF);
  localparam logic [DW-1:0] LIM_NEG = DW'(33'h08000_0000);

  logic                        neg;
  logic                        ovf;
  logic [fpqd_pkg::DATA_W-1:0] q;

  // Apply the sign, flag wrap-around and force the zero-divisor result.
  always_comb begin
    neg = in_ctrl.neg && (in_quo != '0);
    ovf = neg ? (in_quo > LIM_NEG) : (in_quo > LIM_POS);
    q   = neg ? (~in_quo[fpqd_pkg::DATA_W-1:0] + 1'b1) : in_quo[fpqd_pkg::DATA_W-1:0];
    if (in_ctrl.dz) begin
      q   = '0;
      ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient       <= q;
    overflow       <= ovf;
    divide_by_zero <= in_ctrl.dz;
  end

endmodule

[design/fixed_point_q16_divider_core.sv]
// Signed fixed-point divider, FRAC_BITS fraction bits (Q16.16 by default).
//
// Input channel: drive dividend and divisor and raise start; the item is
// taken at the rising edge where start is high and busy is low. busy is
// held low, so an item may be issued in every cycle.
//
// Output channel: done is high for exactly one cycle with quotient,
// overflow and divide_by_zero valid alongside it. The receiver cannot stall
// the block, so results must be captured in that cycle; they leave in the
// order the items entered.
//
// Pipeline: the accepting edge loads the sign and magnitude stage; then follow
// one restoring-division stage per quotient bit (32 + FRAC_BITS of them) and
// a final register stage for sign correction and overflow. Throughput: one
// item per cycle, set by the fully pipelined chain of compare-and-subtract
// stages.
//
// Reset: rst clears every valid bit in the pipeline; items in flight are
// dropped and no done pulse follows for them.
`include "assert_macros.svh"

module fixed_point_q16_divider_core #(
  parameter int FRAC_BITS = fpqd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [fpqd_pkg::DATA_W-1:0]     dividend,
  input  logic [fpqd_pkg::DATA_W-1:0]     divisor,
  output logic                            done,
  output logic [fpqd_pkg::DATA_W-1:0]     quotient,
  output logic                            overflow,
  output logic                            divide_by_zero
);

  // Quotient bits to develop: widened dividend width.
  localparam int DW  = fpqd_pkg::DATA_W + FRAC_BITS;
  // Edges from acceptance to the edge that takes the result.
  localparam int LAT = DW + 2;

  fpqd_pkg::ctrl_t               ctrl_s [0:DW];
  logic [DW-1:0]                 num_s  [0:DW];
  logic [DW-1:0]                 quo_s  [0:DW];
  logic [fpqd_pkg::DATA_W-1:0]   rem_s  [0:DW];
  logic [fpqd_pkg::DATA_W-1:0]   den_s  [0:DW];

  // Every stage advances each cycle; nothing ever holds the input off.
  assign busy = 1'b0;

  // Stage zero: capture signs, take magnitudes, align the dividend.
  fpqd_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .dividend (dividend),
    .divisor  (divisor),
    .ctrl     (ctrl_s[0]),
    .num      (num_s[0]),
    .den      (den_s[0])
  );

  // Division starts with an empty partial remainder and quotient.
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;

  // One registered restoring step per quotient bit, MSB first.
  for (genvar i = 0; i < DW; i++) begin : g_stage
    fpqd_div_stage #(.DW(DW)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_ctrl  (ctrl_s[i]),
      .in_num   (num_s[i]),
      .in_quo   (quo_s[i]),
      .in_rem   (rem_s[i]),
      .in_den   (den_s[i]),
      .out_ctrl (ctrl_s[i+1]),
      .out_num  (num_s[i+1]),
      .out_quo  (quo_s[i+1]),
      .out_rem  (rem_s[i+1]),
      .out_den  (den_s[i+1])
    );
  end

  // Final stage: restore the sign, detect wrap, force the zero-divisor case.
  fpqd_post #(.DW(DW)) u_post (
    .clk            (clk),
    .rst            (rst),
    .in_ctrl        (ctrl_s[DW]),
    .in_quo         (quo_s[DW]),
    .done           (done),
    .quotient       (quotient),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

  // Every accepted item yields a strobe after the fixed latency.
  `ASSERT_IMPLY(a_item_completes, clk, rst, start && !busy, ##LAT done)
  // A strobe always traces back to an accepted item.
  `ASSERT_IMPLY(a_done_has_item, clk, rst, done, $past(start && !busy, LAT))
  // A zero divisor gives a clean zero result.
  `ASSERT_IMPLY(a_dz_zero, clk, rst, done && divide_by_zero, quotient == '0 && !overflow)
  // A nonzero in-range result carries the sign of the operand sign product.
  `ASSERT_IMPLY(a_sign_ok, clk, rst, done && !divide_by_zero && !overflow && quotient != '0, quotient[fpqd_pkg::DATA_W-1] == $past(dividend[fpqd_pkg::DATA_W-1] ^ divisor[fpqd_pkg::DATA_W-1], LAT))

endmodule
